### hw/rtl/bsc_pkg.sv
package bsc_pkg;
	localparam int unsigned DataW = 32;
	localparam int unsigned ModeW = 3;
	localparam int unsigned RawW = 16;
	localparam int unsigned CfgIdxW = 2;
	localparam int unsigned CfgDataW = 64;
	localparam int unsigned CntW = 6;

	localparam logic [CfgIdxW-1:0] REG_CALIB_FIRST = 2'd0;
	localparam logic [CfgIdxW-1:0] REG_CALIB_SECOND = 2'd1;
	localparam logic [CfgIdxW-1:0] REG_CALIB_THIRD = 2'd2;

	localparam logic [ModeW-1:0] MODE_TEMP = 3'd0;

	// serial unit operations
	typedef enum logic [1:0] {
		OP_MUL,
		OP_DIVU,
		OP_DIVS
	} op_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_T1, ST_T2, ST_T3, ST_T4,
		ST_P1, ST_P2, ST_P3, ST_P4, ST_P5, ST_P6, ST_P7, ST_P8,
		ST_P9, ST_P10, ST_P11, ST_P12, ST_P13, ST_P14, ST_P15,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic start;
		op_t op;
		logic [DataW-1:0] a;
		logic [DataW-1:0] b;
	} su_req_t;

	typedef struct packed {
		logic done;
		logic [DataW-1:0] res;
	} su_rsp_t;

	// signed truncating divide by 2^k on a bit pattern
	function automatic logic [DataW-1:0] sdiv_pow2(input logic [DataW-1:0] a,
			input logic [4:0] k);
		logic [DataW-1:0] m;
		logic [DataW-1:0] q;
		begin
			m = a[DataW-1] ? (~a + 1'b1) : a;
			q = m >> k;
			sdiv_pow2 = a[DataW-1] ? (~q + 1'b1) : q;
		end
	endfunction

	function automatic logic [DataW-1:0] sext16(input logic [15:0] w);
		sext16 = {{(DataW-16){w[15]}}, w};
	endfunction
endpackage

### hw/rtl/bsc_if.sv
interface bsc_in_if;
	import bsc_pkg::*;
	logic valid;
	logic ready;
	logic [ModeW-1:0] mode;
	logic [RawW-1:0] raw_reading;
	modport source (output valid, mode, raw_reading, input ready);
	modport sink (input valid, mode, raw_reading, output ready);
endinterface

interface bsc_out_if;
	import bsc_pkg::*;
	logic valid;
	logic ready;
	logic signed [DataW-1:0] value;
	logic is_pressure;
	logic divide_error;
	modport source (output valid, value, is_pressure, divide_error, input ready);
	modport sink (input valid, value, is_pressure, divide_error, output ready);
endinterface

interface bsc_cfg_if;
	import bsc_pkg::*;
	logic valid;
	logic ready;
	logic [CfgIdxW-1:0] index;
	logic [CfgDataW-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

### hw/rtl/bsc_serial_unit.sv
module bsc_serial_unit (
	input  logic clk,
	input  logic arst_n,
	input  bsc_pkg::su_req_t req,
	output bsc_pkg::su_rsp_t rsp
);
	import bsc_pkg::*;

	logic busy_q;
	logic done_q;
	logic [CntW-1:0] cnt_q;
	op_t op_q;
	logic [DataW-1:0] acc_q;
	logic [DataW-1:0] sh_q;
	logic [DataW-1:0] b_q;
	logic [DataW-1:0] rem_q;
	logic neg_q;
	logic [DataW+1:0] trial;
	logic [DataW:0] rem_sh;
	logic [DataW-1:0] ma;
	logic [DataW-1:0] mb;
	logic last;

	// partial remainder can reach 33 bits before the compare
	assign rem_sh = {rem_q, sh_q[DataW-1]};
	assign trial = {1'b0, rem_sh} - {2'b00, b_q};
	assign last = (cnt_q == CntW'(DataW-1));

	always_comb begin
		ma = req.a;
		mb = req.b;
		if (req.op == OP_DIVS) begin
			ma = req.a[DataW-1] ? (~req.a + 1'b1) : req.a;
			mb = req.b[DataW-1] ? (~req.b + 1'b1) : req.b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (last) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			op_q <= req.op;
			acc_q <= '0;
			sh_q <= ma;
			b_q <= mb;
			rem_q <= '0;
			neg_q <= (req.op == OP_DIVS) && (req.a[DataW-1] ^ req.b[DataW-1]);
		end else if (busy_q) begin
			if (op_q == OP_MUL) begin
				// lsb-first shift-add, modulo 2^32
				if (sh_q[0]) acc_q <= acc_q + (b_q << cnt_q[4:0]);
				sh_q <= sh_q >> 1;
			end else begin
				// restoring division, one quotient bit a cycle
				if (!trial[DataW+1]) rem_q <= trial[DataW-1:0];
				else rem_q <= rem_sh[DataW-1:0];
				acc_q <= {acc_q[DataW-2:0], ~trial[DataW+1]};
				sh_q <= sh_q << 1;
			end
		end
	end

	assign rsp = '{done: done_q, res: (neg_q ? (~acc_q + 1'b1) : acc_q)};
endmodule

### hw/rtl/barometric_sensor_compensation_unit.sv
// Barometric sensor compensation. One item (mode, raw reading) gives one result:
// mode 0 compensates temperature in 0.1 degree units and stores the intermediate
// term, modes 1 to 4 (5 to 7 as 4) give pressure in pascals from the last stored
// term. All multiplies and divides run through one shared bit-serial unit: each
// operation slot is a load, 32 bit steps, then the hand-over to the next slot.
// A temperature item uses three slots and a pressure item twelve. A zero divisor
// gives value 0 with divide_error and ends the sequence early. The user must write
// calibration through the config channel only while idle; the block itself does
// not enforce it. Items are taken one at a time.
module barometric_sensor_compensation_unit (
	input  logic clk,
	input  logic arst_n,
	bsc_cfg_if.sink cfg,
	bsc_in_if.sink in_ch,
	bsc_out_if.source out_ch
);
	import bsc_pkg::*;

	logic [CfgDataW-1:0] c1_q, c2_q;
	logic [47:0] c3_q;
	logic [DataW-1:0] temp_term_q;
	state_t state_q, state_d;
	logic [1:0] oss_q;
	logic [RawW-1:0] raw_q;
	logic issued_q;
	logic [DataW-1:0] b6_q, sq_q, x1_q, t_q, b4_q, b7_q, p_q, res_q;
	logic err_q, isp_q;
	su_req_t req;
	su_rsp_t rsp;

	logic [DataW-1:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
	assign ac1 = sext16(c1_q[15:0]);
	assign ac2 = sext16(c1_q[31:16]);
	assign ac3 = sext16(c1_q[47:32]);
	assign ac4 = {16'd0, c1_q[63:48]};
	assign ac5 = {16'd0, c2_q[15:0]};
	assign ac6 = {16'd0, c2_q[31:16]};
	assign b1 = sext16(c2_q[47:32]);
	assign b2 = sext16(c2_q[63:48]);
	assign mc = sext16(c3_q[31:16]);
	assign md = sext16(c3_q[47:32]);

	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c1_q <= '0;
			c2_q <= '0;
			c3_q <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_CALIB_FIRST: c1_q <= cfg.data;
				REG_CALIB_SECOND: c2_q <= cfg.data;
				REG_CALIB_THIRD: c3_q <= cfg.data[47:0];
				default: ;
			endcase
		end
	end

	bsc_serial_unit u_su (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp));

	// handy derived values for the sequence
	logic [DataW-1:0] r, up, b3, den, q_h, x3p;
	assign r = rsp.res;
	assign up = {16'd0, raw_q} << oss_q;
	assign den = x1_q + md;

	// ready: the step waits for the unit except where it only latches
	logic step;
	assign step = rsp.done;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (in_ch.valid) state_d = (in_ch.mode == MODE_TEMP) ? ST_T1 : ST_P1;
			ST_T1: if (step) state_d = ST_T2;
			ST_T2: if (step) state_d = (den == '0) ? ST_OUT : ST_T3;
			ST_T3: if (step) state_d = ST_OUT;
			ST_P1: if (step) state_d = ST_P2;
			ST_P2: if (step) state_d = ST_P3;
			ST_P3: if (step) state_d = ST_P4;
			ST_P4: if (step) state_d = ST_P5;
			ST_P5: if (step) state_d = ST_P6;
			ST_P6: if (step) state_d = ST_P7;
			ST_P7: if (step) state_d = ST_P8;
			// zero b4: no division issued, straight to the result
			ST_P8: begin
				if (b4_q == '0) state_d = ST_OUT;
				else if (step) state_d = ST_P9;
			end
			ST_P9: if (step) state_d = ST_P10;
			ST_P10: if (step) state_d = ST_P11;
			ST_P11: if (step) state_d = ST_P12;
			ST_P12: if (step) state_d = ST_OUT;
			ST_OUT: if (out_ch.ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// b3 from x3 = x1 + x2 held in t_q
	assign b3 = sdiv_pow2((((ac1 << 2) + t_q) << oss_q) + 32'd2, 5'd2);
	assign q_h = sdiv_pow2(p_q, 5'd8);
	assign x3p = sdiv_pow2(x1_q + sdiv_pow2(r, 5'd16) + 32'd2, 5'd2);

	// operation issued on entry to each compute state
	always_comb begin
		req = '0;
		req.start = !issued_q;
		case (state_q)
			ST_T1: begin req.op = OP_MUL; req.a = {16'd0, raw_q} - ac6; req.b = ac5; end
			ST_T2: begin req.op = OP_DIVS; req.a = mc << 11; req.b = den; end
			ST_T3: begin req.op = OP_MUL; req.a = '0; req.b = '0; end
			ST_P1: begin req.op = OP_MUL; req.a = b6_q; req.b = b6_q; end
			ST_P2: begin req.op = OP_MUL; req.a = b2; req.b = sq_q; end
			ST_P3: begin req.op = OP_MUL; req.a = ac2; req.b = b6_q; end
			ST_P4: begin req.op = OP_MUL; req.a = ac3; req.b = b6_q; end
			ST_P5: begin req.op = OP_MUL; req.a = b1; req.b = sq_q; end
			ST_P6: begin req.op = OP_MUL; req.a = ac4; req.b = t_q + 32'd32768; end
			ST_P7: begin req.op = OP_MUL; req.a = up - b3; req.b = 32'd50000 >> oss_q; end
			ST_P8: begin
				req.op = OP_DIVU;
				req.a = b7_q[DataW-1] ? b7_q : (b7_q << 1);
				req.b = b4_q;
			end
			ST_P9: begin req.op = OP_MUL; req.a = q_h; req.b = q_h; end
			ST_P10: begin req.op = OP_MUL; req.a = r; req.b = 32'd3038; end
			ST_P11: begin req.op = OP_MUL; req.a = 32'd0 - 32'd7357; req.b = p_q; end
			ST_P12: begin req.op = OP_MUL; req.a = '0; req.b = '0; end
			default: req.start = 1'b0;
		endcase
		if (state_q == ST_P8 && b4_q == '0) req.start = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			issued_q <= 1'b1;
			temp_term_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_d != state_q) issued_q <= (state_d == ST_OUT) || (state_d == ST_IDLE);
			else if (req.start) issued_q <= 1'b1;
			if (state_q == ST_T2 && step && den != '0)
				temp_term_q <= x1_q + r;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: if (in_ch.valid) begin
				raw_q <= in_ch.raw_reading;
				oss_q <= (in_ch.mode > 3'd4) ? 2'd3 : 2'(in_ch.mode - 3'd1);
				isp_q <= (in_ch.mode != MODE_TEMP);
				err_q <= 1'b0;
				res_q <= '0;
				b6_q <= temp_term_q - 32'd4000;
			end
			ST_T1: if (step) x1_q <= sdiv_pow2(r, 5'd15);
			ST_T2: if (step) begin
				if (den == '0) err_q <= 1'b1;
				else res_q <= sdiv_pow2(x1_q + r + 32'd8, 5'd4);
			end
			ST_P1: if (step) sq_q <= sdiv_pow2(r, 5'd12);
			ST_P2: if (step) t_q <= sdiv_pow2(r, 5'd11);
			ST_P3: if (step) t_q <= t_q + sdiv_pow2(r, 5'd11);
			ST_P4: if (step) begin x1_q <= sdiv_pow2(r, 5'd13); b7_q <= t_q; end
			ST_P5: if (step) t_q <= x3p;
			ST_P6: if (step) begin b4_q <= r >> 15; t_q <= b7_q; end
			ST_P7: if (step) b7_q <= r;
			ST_P8: if (b4_q == '0) err_q <= 1'b1;
				else if (step) p_q <= b7_q[DataW-1] ? (r << 1) : r;
			ST_P9: if (step) t_q <= r;
			ST_P10: if (step) x1_q <= sdiv_pow2(r, 5'd16);
			ST_P11: if (step)
				res_q <= p_q + sdiv_pow2(x1_q + sdiv_pow2(r, 5'd16) + 32'd3791, 5'd4);
			default: ;
		endcase
	end

	assign in_ch.ready = (state_q == ST_IDLE);
	assign out_ch.valid = (state_q == ST_OUT);
	assign out_ch.value = res_q;
	assign out_ch.is_pressure = isp_q;
	assign out_ch.divide_error = err_q;
endmodule

### hw/rtl/bsc_checker.sv
module bsc_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic [31:0] out_value,
	input logic out_err
);
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_err |-> out_value == 32'd0) else $error("error with value");
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("ready while result pending");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_value)) else $error("drop");
	a_gap: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !out_valid) else $error("too fast");
endmodule

bind barometric_sensor_compensation_unit bsc_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_value(out_ch.value),
	.out_err(out_ch.divide_error));
